[rtl/core/assert_macros.svh]
// Assertion macros shared by the button qualifier RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/bprq_pkg.sv]
// Package for the button press repeat qualifier: sizes, register map and payload types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package bprq_pkg;

  localparam int NUM_BUTTONS       = 6;
  localparam int EXIT_BUTTON_INDEX = 4;
  localparam int NUM_REGS          = 4;
  localparam int REG_IDX_W         = $clog2(NUM_REGS);
  localparam int PADDR_W           = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_FIRST_REPEAT = 2'd1,
    REG_NEXT_REPEAT  = 2'd2,
    REG_HAPTIC_MASK  = 2'd3
  } reg_idx_e;

  localparam logic [15:0]            LONG_PRESS_RESET   = 16'd500;
  localparam logic [7:0]             FIRST_REPEAT_RESET = 8'd30;
  localparam logic [7:0]             NEXT_REPEAT_RESET  = 8'd5;
  localparam logic [NUM_BUTTONS-1:0] HAPTIC_MASK_RESET  = NUM_BUTTONS'(1);

  typedef struct packed {
    logic [15:0]            long_press_ticks;
    logic [7:0]             first_repeat_polls;
    logic [7:0]             next_repeat_polls;
    logic [NUM_BUTTONS-1:0] haptic_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [15:0]            now_ticks;
    logic [NUM_BUTTONS-1:0] button_levels;
    logic                   power_level;
    logic                   charge_level;
    logic                   waiting_for_left;
  } poll_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] short_events;
    logic [NUM_BUTTONS-1:0] long_events;
    logic [NUM_BUTTONS-1:0] haptic_pulses;
    logic                   select_held;
    logic                   left_exit;
    logic                   power_request;
    logic                   charging_started;
    logic                   charging_stopped;
    logic                   battery_read_request;
  } result_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic haptic;
    logic exit_set;
    logic exit_clr;
  } lane_ev_t;

endpackage

[rtl/core/bprq_lane.sv]
// One button lane: press, long-press and auto-repeat qualification for a single button.
// Depends on bprq_pkg.
`timescale 1ns / 1ps
module bprq_lane
  import bprq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        level_i,
  input  logic        is_exit_i,
  input  logic        haptic_en_i,
  input  logic        waiting_i,
  input  logic [15:0] now_i,
  input  cfg_t        cfg_i,
  output lane_ev_t    ev_o
);

  logic        prev_q, prev_d;
  logic        fired_q, fired_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] start_q, start_d;
  logic [15:0] held;

  assign held = now_i - start_q;

  always_comb begin
    prev_d  = level_i;
    fired_d = fired_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    ev_o    = '0;
    if (!level_i) begin
      if (prev_q) begin
        start_d     = now_i;
        fired_d     = 1'b0;
        cnt_d       = cfg_i.first_repeat_polls;
        ev_o.haptic = haptic_en_i;
      end else begin
        if (!fired_q && (held >= cfg_i.long_press_ticks)) begin
          fired_d      = 1'b1;
          ev_o.long_ev = 1'b1;
        end
        if (cnt_q == 8'd0) begin
          ev_o.short_ev = 1'b1;
          cnt_d         = cfg_i.next_repeat_polls;
        end else begin
          cnt_d = cnt_q - 8'd1;
        end
      end
    end else if (!prev_q) begin
      cnt_d = 8'd0;
      if (!fired_q) begin
        if (waiting_i && is_exit_i) begin
          ev_o.exit_set = 1'b1;
        end else begin
          ev_o.short_ev = 1'b1;
          ev_o.exit_clr = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      fired_q <= 1'b0;
      cnt_q   <= 8'd0;
      start_q <= 16'd0;
    end else if (accept_i) begin
      prev_q  <= prev_d;
      fired_q <= fired_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

endmodule

[rtl/core/bprq_merge.sv]
// Merging stage: combines lane events into one result and tracks exit and charge state.
// Depends on bprq_pkg.
`timescale 1ns / 1ps
module bprq_merge
  import bprq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  poll_t    poll_i,
  input  lane_ev_t ev_i [NUM_BUTTONS],
  output result_t  res_o
);

  logic exit_q, exit_d;
  logic was_chg_q, was_chg_d;
  logic known_q, known_d;
  logic is_chg;
  logic chg_event;

  assign is_chg    = ~poll_i.charge_level;
  assign chg_event = ~known_q | (is_chg ^ was_chg_q);

  always_comb begin
    exit_d = exit_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (ev_i[i].exit_set) begin
        exit_d = 1'b1;
      end else if (ev_i[i].exit_clr) begin
        exit_d = 1'b0;
      end
    end
    was_chg_d = chg_event ? is_chg : was_chg_q;
    known_d   = 1'b1;
  end

  always_comb begin
    res_o = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      res_o.short_events[i]  = ev_i[i].short_ev;
      res_o.long_events[i]   = ev_i[i].long_ev;
      res_o.haptic_pulses[i] = ev_i[i].haptic;
    end
    res_o.select_held          = ~poll_i.button_levels[0];
    res_o.left_exit            = exit_d;
    res_o.power_request        = ~poll_i.power_level;
    res_o.charging_started     = chg_event & is_chg;
    res_o.charging_stopped     = chg_event & ~is_chg;
    res_o.battery_read_request = chg_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_q    <= 1'b0;
      was_chg_q <= 1'b0;
      known_q   <= 1'b0;
    end else if (accept_i) begin
      exit_q    <= exit_d;
      was_chg_q <= was_chg_d;
      known_q   <= known_d;
    end
  end

endmodule

[rtl/core/button_press_repeat_qualifier_core.sv]
// Top level of the button press repeat qualifier: register port, button lanes,
// merging stage and output register. Depends on bprq_pkg, bprq_lane, bprq_merge.
//
// Usage: each input transaction on in_valid_i/in_ready_o carries one poll of the
// buttons, the power and charge levels and the exit-wait flag. Every poll gives
// exactly one output transaction on out_valid_o/out_ready_i with the short,
// long and haptic bits per button and the power and charge pulses.
// The result shows in the cycle after acceptance; one poll is taken per cycle
// while the receiver takes each result; each button lane updates its state in
// the cycle of acceptance and the merging stage resolves the exit flag in the
// same cycle, so the single output register sets the rate.
// When the receiver stalls, the result holds in the output register and
// in_ready_o is low until it is taken.
// Reset clears all button state to released, the charge state to unknown (the
// first poll then reports it) and loads the register reset values. The APB-style
// register port has pready always high; registers lie at byte addresses 0, 4, 8
// and 12. Write them only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module button_press_repeat_qualifier_core
  import bprq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  poll_t              in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output result_t            out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg_q;
  logic     cfg_we;
  reg_idx_e reg_idx;
  logic     accept;
  logic     out_valid_q;
  result_t  out_q;
  result_t  res;
  lane_ev_t ev [NUM_BUTTONS];

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= LONG_PRESS_RESET;
      cfg_q.first_repeat_polls <= FIRST_REPEAT_RESET;
      cfg_q.next_repeat_polls  <= NEXT_REPEAT_RESET;
      cfg_q.haptic_enable_mask <= HAPTIC_MASK_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_LONG_PRESS:   cfg_q.long_press_ticks   <= pwdata[15:0];
        REG_FIRST_REPEAT: cfg_q.first_repeat_polls <= pwdata[7:0];
        REG_NEXT_REPEAT:  cfg_q.next_repeat_polls  <= pwdata[7:0];
        REG_HAPTIC_MASK:  cfg_q.haptic_enable_mask <= pwdata[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LONG_PRESS:   prdata = 32'(cfg_q.long_press_ticks);
      REG_FIRST_REPEAT: prdata = 32'(cfg_q.first_repeat_polls);
      REG_NEXT_REPEAT:  prdata = 32'(cfg_q.next_repeat_polls);
      REG_HAPTIC_MASK:  prdata = 32'(cfg_q.haptic_enable_mask);
      default:          prdata = '0;
    endcase
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bprq_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .accept_i    (accept),
      .level_i     (in_data_i.button_levels[g]),
      .is_exit_i   ((g == EXIT_BUTTON_INDEX) ? 1'b1 : 1'b0),
      .haptic_en_i (cfg_q.haptic_enable_mask[g]),
      .waiting_i   (in_data_i.waiting_for_left),
      .now_i       (in_data_i.now_ticks),
      .cfg_i       (cfg_q),
      .ev_o        (ev[g])
    );
  end

  bprq_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .poll_i   (in_data_i),
    .ev_i     (ev),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_RST(a_accept_gives_result, clk_i, rst_ni, accept |=> out_valid_q)
  `ASSERT_RST(a_stall_blocks_input, clk_i, rst_ni, (out_valid_q && !out_ready_i) |-> !in_ready_o)
  `ASSERT_RST(a_select_follows_poll, clk_i, rst_ni, accept |=> (out_q.select_held == !$past(in_data_i.button_levels[0])))
  `ASSERT_RST(a_power_follows_poll, clk_i, rst_ni, accept |=> (out_q.power_request == !$past(in_data_i.power_level)))

endmodule
